FILE: hw/rtl/bmss_pkg.sv
// shared types and constants for the block merge split sorter
package bmss_pkg;

  localparam int MAX_VALUES_DEF = 64;
  localparam int VALUE_W        = 8;

  // datapath commands issued by the controller
  typedef struct packed {
    logic load;       // capture incoming item, start insertion at the top
    logic rd_prev;    // read the slot below the insertion point
    logic shift;      // move the read slot up one place
    logic place;      // write the held value at the insertion point
    logic emit_start; // reset the output index
    logic emit_rd;    // read the slot at the output index
    logic emit_adv;   // step the output index
    logic clear;      // empty the store
  } cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic full;       // store holds the maximum number of values
    logic j_zero;     // insertion point at slot zero
    logic greater;    // read slot is above the held value
    logic emit_last;  // output index is on the final stored value
  } status_t;

endpackage

FILE: hw/rtl/bmss_datapath.sv
// value store, insertion datapath and output register
module bmss_datapath #(
  parameter int MAX_VALUES = bmss_pkg::MAX_VALUES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bmss_pkg::cmd_t               cmd,
  input  logic [bmss_pkg::VALUE_W-1:0] value,
  output bmss_pkg::status_t            status,
  output logic [bmss_pkg::VALUE_W-1:0] rdata
);

  localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int CW = $clog2(MAX_VALUES + 1);

  logic [bmss_pkg::VALUE_W-1:0] mem [MAX_VALUES];
  logic [bmss_pkg::VALUE_W-1:0] hold;
  logic [CW-1:0]                count;
  logic [AW-1:0]                j;
  logic [AW-1:0]                i;
  logic [AW-1:0]                raddr;
  logic [AW-1:0]                waddr;
  logic [bmss_pkg::VALUE_W-1:0] wdata;

  // one read port shared by insertion and output
  assign raddr = cmd.emit_rd ? i : AW'(j - AW'(1));
  assign waddr = j;
  assign wdata = cmd.shift ? rdata : hold;

  // store memory with registered read
  always_ff @(posedge clk) begin
    if (cmd.shift || cmd.place) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_prev || cmd.emit_rd) begin
      rdata <= mem[raddr];
    end
  end

  // insertion point, held value and output index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hold <= value;
      j    <= count[AW-1:0];
    end else if (cmd.shift) begin
      j <= AW'(j - AW'(1));
    end
    if (cmd.emit_start) begin
      i <= '0;
    end else if (cmd.emit_adv) begin
      i <= AW'(i + AW'(1));
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
    end else if (cmd.place) begin
      count <= CW'(count + CW'(1));
    end
  end

  assign status.full      = (count == CW'(MAX_VALUES));
  assign status.j_zero    = (j == '0);
  assign status.greater   = (rdata > hold);
  assign status.emit_last = (CW'(i) + CW'(1) == count);

endmodule

FILE: hw/rtl/bmss_ctrl.sv
// controller state machine for loading, insertion and output
module bmss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bmss_pkg::status_t status,
  output bmss_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_ERD  = 3'd3;
  localparam logic [2:0] S_EOUT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       last_flag;
  logic       last_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_flag <= 1'b0;
    end else begin
      state     <= state_next;
      last_flag <= last_flag_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EOUT);

  // next state and commands
  always_comb begin
    state_next     = state;
    last_flag_next = last_flag;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          last_flag_next = in_last;
          if (!status.full) begin
            cmd.load   = 1'b1;
            state_next = S_RD;
          end else if (in_last) begin
            cmd.emit_start = 1'b1;
            state_next     = S_ERD;
          end
        end
      end
      S_RD: begin
        if (status.j_zero) begin
          cmd.place      = 1'b1;
          cmd.emit_start = last_flag;
          state_next     = last_flag ? S_ERD : S_IDLE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        if (status.greater) begin
          cmd.shift  = 1'b1;
          state_next = S_RD;
        end else begin
          cmd.place      = 1'b1;
          cmd.emit_start = last_flag;
          state_next     = last_flag ? S_ERD : S_IDLE;
        end
      end
      S_ERD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EOUT;
      end
      S_EOUT: begin
        if (out_ready) begin
          if (status.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.emit_adv = 1'b1;
            state_next   = S_ERD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/block_merge_split_sorter.sv
// top level of the block merge split sorter
// each accepted item is inserted into a sorted store, or dropped if the store is
// full: stored values above it are read and shifted up one place at a time until
// a lower value or slot zero stops the scan, through the single store port
// after the item marked last, each result is read from the store and then offered
// until taken; the next batch is taken after the final result
// rst is synchronous, active high, and empties the store and the controller
module block_merge_split_sorter #(
  parameter int MAX_VALUES = bmss_pkg::MAX_VALUES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] value
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] sorted_value
  output logic       m_tlast
);

  bmss_pkg::cmd_t    cmd;
  bmss_pkg::status_t status;

  bmss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bmss_datapath #(.MAX_VALUES(MAX_VALUES)) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .value  (s_tdata),
    .status (status),
    .rdata  (m_tdata)
  );

  assign m_tlast = status.emit_last;

endmodule

FILE: hw/rtl/bmss_checker.sv
// port checker for the block merge split sorter
module bmss_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // input and output sides never open together
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is offered");

  // final result returns the block to loading
  a_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("block not idle after final result");

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

  // nothing is offered right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

endmodule

bind block_merge_split_sorter bmss_checker u_bmss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
